FILE: hdl/csw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_pkg
// Shared types, operation codes and the seven-segment table for the
// clock/stopwatch core.
// ----------------------------------------------------------------------------
package csw_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic       kind;
    logic [3:0] key_bits;
  } in_item_t;

  typedef struct packed {
    logic [6:0] digit3_segments;
    logic [6:0] digit2_segments;
    logic [6:0] digit1_segments;
    logic [6:0] digit0_segments;
  } out_item_t;

  // operations decoded by the front end
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_RUN   = 2'd2,
    OP_MODE  = 2'd3
  } csw_op_e;

  typedef struct packed {
    logic    valid;
    csw_op_e op;
  } csw_req_t;

  localparam logic [0:0] KindTick = 1'b0;

  function automatic logic [6:0] seg_of(logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h3F;
    endcase
    return seg;
  endfunction

endpackage

FILE: hdl/csw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_front
// Accepts input transactions and decodes them into queue operations.
// ----------------------------------------------------------------------------
module csw_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  csw_pkg::in_item_t in_item_i,
  input  logic              queue_full_i,
  output csw_pkg::csw_req_t push_o
);
  import csw_pkg::*;

  logic    has_op;
  csw_op_e op;

  always_comb begin
    has_op = 1'b1;
    op     = OP_TICK;
    if (in_item_i.kind != KindTick) begin
      // highest set key wins, bit 0 alone does nothing
      if (in_item_i.key_bits[3]) begin
        op = OP_CLEAR;
      end else if (in_item_i.key_bits[2]) begin
        op = OP_RUN;
      end else if (in_item_i.key_bits[1]) begin
        op = OP_MODE;
      end else begin
        has_op = 1'b0;
      end
    end
  end

  assign in_ready_o   = !queue_full_i;
  assign push_o.valid = in_valid_i && in_ready_o && has_op;
  assign push_o.op    = op;

endmodule

FILE: hdl/csw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_queue
// Short operation queue between the front end and the time-keeping back end.
// ----------------------------------------------------------------------------
module csw_queue #(
  parameter int unsigned Depth = csw_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csw_pkg::csw_req_t push_i,
  output logic              full_o,
  output csw_pkg::csw_req_t pop_o,
  input  logic              pop_ready_i
);
  import csw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  csw_op_e         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o      = (count_q == FullCnt);
  assign pop_o.valid = (count_q != '0);
  assign pop_o.op    = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_o.valid && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.op;
    end
  end

endmodule

FILE: hdl/csw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_back
// Time-keeping back end: BCD clock and stopwatch counters, mode flags and
// the registered display output.
// ----------------------------------------------------------------------------
module csw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csw_pkg::csw_req_t  pop_i,
  output logic               pop_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output csw_pkg::out_item_t out_item_o
);
  import csw_pkg::*;

  // counters are held as BCD digit pairs
  logic [3:0] ws_one_q, ws_one_d;
  logic [2:0] ws_ten_q, ws_ten_d;
  logic [3:0] wm_one_q, wm_one_d;
  logic [2:0] wm_ten_q, wm_ten_d;
  logic [3:0] cs_one_q, cs_one_d;
  logic [2:0] cs_ten_q, cs_ten_d;
  logic [3:0] cm_one_q, cm_one_d;
  logic [2:0] cm_ten_q, cm_ten_d;
  logic [3:0] ch_one_q, ch_one_d;
  logic [1:0] ch_ten_q, ch_ten_d;
  logic       running_q, running_d;
  logic       show_clock_q, show_clock_d;

  logic       out_valid_q;
  out_item_t  out_q;
  out_item_t  disp;
  logic       fire, fire_tick;
  logic       ws_wrap, wm_wrap_unused, cs_wrap, cm_wrap;

  assign pop_ready_o = (pop_i.op != OP_TICK) || !out_valid_q || out_ready_i;
  assign fire        = pop_i.valid && pop_ready_o;
  assign fire_tick   = fire && (pop_i.op == OP_TICK);

  assign ws_wrap        = (ws_one_q == 4'd9) && (ws_ten_q == 3'd5);
  assign wm_wrap_unused = (wm_one_q == 4'd9) && (wm_ten_q == 3'd5);
  assign cs_wrap        = (cs_one_q == 4'd9) && (cs_ten_q == 3'd5);
  assign cm_wrap        = (cm_one_q == 4'd9) && (cm_ten_q == 3'd5);

  always_comb begin
    if (show_clock_q) begin
      disp.digit0_segments = seg_of(cm_one_q);
      disp.digit1_segments = seg_of({1'b0, cm_ten_q});
      disp.digit2_segments = seg_of(ch_one_q);
      disp.digit3_segments = seg_of({2'b00, ch_ten_q});
    end else begin
      disp.digit0_segments = seg_of(ws_one_q);
      disp.digit1_segments = seg_of({1'b0, ws_ten_q});
      disp.digit2_segments = seg_of(wm_one_q);
      disp.digit3_segments = seg_of({1'b0, wm_ten_q});
    end
  end

  always_comb begin
    ws_one_d     = ws_one_q;
    ws_ten_d     = ws_ten_q;
    wm_one_d     = wm_one_q;
    wm_ten_d     = wm_ten_q;
    cs_one_d     = cs_one_q;
    cs_ten_d     = cs_ten_q;
    cm_one_d     = cm_one_q;
    cm_ten_d     = cm_ten_q;
    ch_one_d     = ch_one_q;
    ch_ten_d     = ch_ten_q;
    running_d    = running_q;
    show_clock_d = show_clock_q;
    if (fire) begin
      case (pop_i.op)
        OP_CLEAR: begin
          ws_one_d  = '0;
          ws_ten_d  = '0;
          wm_one_d  = '0;
          wm_ten_d  = '0;
          running_d = 1'b0;
        end
        OP_RUN: begin
          running_d = !running_q;
        end
        OP_MODE: begin
          show_clock_d = !show_clock_q;
        end
        OP_TICK: begin
          if (running_q) begin
            if (ws_one_q == 4'd9) begin
              ws_one_d = '0;
              ws_ten_d = (ws_ten_q == 3'd5) ? '0 : ws_ten_q + 1'b1;
            end else begin
              ws_one_d = ws_one_q + 1'b1;
            end
            if (ws_wrap) begin
              if (wm_one_q == 4'd9) begin
                wm_one_d = '0;
                wm_ten_d = wm_wrap_unused ? '0 : wm_ten_q + 1'b1;
              end else begin
                wm_one_d = wm_one_q + 1'b1;
              end
            end
          end
          if (cs_one_q == 4'd9) begin
            cs_one_d = '0;
            cs_ten_d = (cs_ten_q == 3'd5) ? '0 : cs_ten_q + 1'b1;
          end else begin
            cs_one_d = cs_one_q + 1'b1;
          end
          if (cs_wrap) begin
            if (cm_one_q == 4'd9) begin
              cm_one_d = '0;
              cm_ten_d = (cm_ten_q == 3'd5) ? '0 : cm_ten_q + 1'b1;
            end else begin
              cm_one_d = cm_one_q + 1'b1;
            end
            // hour moves only when the minutes roll over
            if (cm_wrap) begin
              if ((ch_ten_q == 2'd2) && (ch_one_q == 4'd3)) begin
                ch_one_d = '0;
                ch_ten_d = '0;
              end else if (ch_one_q == 4'd9) begin
                ch_one_d = '0;
                ch_ten_d = ch_ten_q + 1'b1;
              end else begin
                ch_one_d = ch_one_q + 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_one_q     <= 4'd0;
      ws_ten_q     <= 3'd0;
      wm_one_q     <= 4'd0;
      wm_ten_q     <= 3'd0;
      cs_one_q     <= 4'd0;
      cs_ten_q     <= 3'd0;
      cm_one_q     <= 4'd0;
      cm_ten_q     <= 3'd4;
      ch_one_q     <= 4'd8;
      ch_ten_q     <= 2'd1;
      running_q    <= 1'b1;
      show_clock_q <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      ws_one_q     <= ws_one_d;
      ws_ten_q     <= ws_ten_d;
      wm_one_q     <= wm_one_d;
      wm_ten_q     <= wm_ten_d;
      cs_one_q     <= cs_one_d;
      cs_ten_q     <= cs_ten_d;
      cm_one_q     <= cm_one_d;
      cm_ten_q     <= cm_ten_d;
      ch_one_q     <= ch_one_d;
      ch_ten_q     <= ch_ten_d;
      running_q    <= running_d;
      show_clock_q <= show_clock_d;
      if (fire_tick) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_tick) begin
      out_q <= disp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: hdl/clock_stopwatch_seven_segment_core.sv
`timescale 1ns / 1ps
// Flow: a tick transaction is written into the operation queue; once the back end
// takes it, its display result is registered in the output register and presented.
// Throughput: one transaction per cycle while the display output is not stalled;
// key transactions give no result.
// Reset: asynchronous, clears the queue and loads clock 18:40:00, stopwatch 00:00
// running, clock mode shown.
// ----------------------------------------------------------------------------
// clock_stopwatch_seven_segment_core
// Time-of-day clock and stopwatch driving four seven-segment digit patterns.
// ----------------------------------------------------------------------------
module clock_stopwatch_seven_segment_core #(
  parameter int unsigned QueueDepth = csw_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  csw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output csw_pkg::out_item_t out_item_o
);
  import csw_pkg::*;

  csw_req_t push;
  csw_req_t pop;
  logic     queue_full;
  logic     pop_ready;

  csw_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  csw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (queue_full),
    .pop_o       (pop),
    .pop_ready_i (pop_ready)
  );

  csw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .pop_ready_o (pop_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
